// ===== sv/i2a_pkg.sv =====
// Shared types, constants and helper functions for the integer to ASCII formatter.
// Used by every module of the block; depends on nothing else.
package i2a_pkg;

    localparam int I2A_VALUE_BITS  = 32;
    localparam int I2A_QUEUE_DEPTH = 2;
    localparam int WIDTH_BITS      = 5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONVERT,
        BK_SIGN,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        radix_t                  radix;
        logic                    neg;
        logic                    upper;
        logic                    zero_fill;
        logic [WIDTH_BITS-1:0]   width;
    } ctl_t;

    // Number of decimal digits needed for the largest value of the given bit count.
    function automatic int dec_digits(input int bits);
        logic [71:0] limit;
        logic [71:0] power;
        int          count;
        limit = 72'(1) << bits;
        power = 72'(1);
        count = 0;
        for (int i = 0; i < 21; i++)
        begin
            if (power < limit)
            begin
                count = count + 1;
            end
            power = power * 72'(10);
        end
        return count;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d <= 4'd9)
        begin
            c = CH_ZERO + 8'(d);
        end
        else if (upper)
        begin
            c = CH_UPPER + 8'(d) - 8'd10;
        end
        else
        begin
            c = CH_LOWER + 8'(d) - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== sv/i2a_front.sv =====
// Input stage of the formatter: accepts a beat, resolves radix and sign,
// and holds the classified number until the queue takes it. Uses i2a_pkg.
module i2a_front #(
    parameter int VALUE_BITS = i2a_pkg::I2A_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [VALUE_BITS-1:0]         value,
    input  logic [1:0]                    radix_select,
    input  logic                          is_signed,
    input  logic                          upper_case,
    input  logic [i2a_pkg::WIDTH_BITS-1:0] min_width,
    input  logic                          zero_fill,
    input  logic                          q_full,
    output logic                          q_push,
    output i2a_pkg::ctl_t                 q_ctl,
    output logic [VALUE_BITS-1:0]         q_mag
);
    import i2a_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic                  accept;
    radix_t                radix;
    logic                  neg;

    assign in_stall = valid_reg && q_full;
    assign q_push   = valid_reg && !q_full;
    assign accept   = in_valid && !in_stall;
    assign q_ctl    = ctl_reg;
    assign q_mag    = mag_reg;

    always_comb
    begin
        case (radix_select)
            RADIX_HEX: radix = RADIX_HEX;
            RADIX_OCT: radix = RADIX_OCT;
            default:   radix = RADIX_DEC;
        endcase
        neg = is_signed && (radix == RADIX_DEC) && value[VALUE_BITS-1];

        ctl_next.radix     = radix;
        ctl_next.neg       = neg;
        ctl_next.upper     = upper_case;
        ctl_next.zero_fill = zero_fill;
        if (neg && (min_width != '0))
        begin
            ctl_next.width = min_width - WIDTH_BITS'(1);
        end
        else
        begin
            ctl_next.width = min_width;
        end
        mag_next = neg ? (~value + VALUE_BITS'(1)) : value;

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg <= ctl_next;
            mag_reg <= mag_next;
        end
    end

endmodule

// ===== sv/i2a_queue.sv =====
// Short register queue that decouples the input stage from the character generator.
// Generic over entry width and depth; uses i2a_pkg for the default depth.
module i2a_queue #(
    parameter int W     = 8,
    parameter int DEPTH = i2a_pkg::I2A_QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] pop_data
);
    import i2a_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/i2a_back.sv =====
// Character generator: converts one queued number to digits (shift-add-3 for
// decimal, direct bit groups otherwise) and sends one character per beat. Uses i2a_pkg.
module i2a_back #(
    parameter int VALUE_BITS = i2a_pkg::I2A_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  i2a_pkg::ctl_t         q_ctl,
    input  logic [VALUE_BITS-1:0] q_mag,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            character,
    output logic                  last
);
    import i2a_pkg::*;

    localparam int NDEC  = dec_digits(VALUE_BITS);
    localparam int NHEX  = (VALUE_BITS + 3) / 4;
    localparam int NOCT  = (VALUE_BITS + 2) / 3;
    localparam int NPOS  = (NDEC > NOCT) ? NDEC : NOCT;
    localparam int POS_W = $clog2(NPOS + 1);
    localparam int IDX_W = $clog2(NPOS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int PADW  = 4 * NPOS;
    localparam int CMP_W = POS_W + WIDTH_BITS;

    bk_state_t             state_reg;
    bk_state_t             state_next;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic [3:0]            digit_reg [NPOS];
    logic [3:0]            digit_next [NPOS];
    logic [3:0]            adj [NPOS];
    logic [PADW-1:0]       pad;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            char_reg;
    logic [7:0]            char_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  room;
    logic [POS_W-1:0]      pos_m1;
    logic [3:0]            cur_digit;
    logic                  show_digit;
    logic                  show_fill;
    logic                  emit;
    logic [7:0]            emit_char;
    logic                  emit_last;
    logic                  step;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    assign room       = !out_valid_reg || !out_stall;
    assign pos_m1     = pos_reg - POS_W'(1);
    assign cur_digit  = digit_reg[pos_m1[IDX_W-1:0]];
    assign show_digit = (cur_digit != 4'd0) || seen_reg || (pos_reg == POS_W'(1));
    assign show_fill  = !show_digit && (CMP_W'(ctl_reg.width) >= CMP_W'(pos_reg));
    assign pad        = PADW'(q_mag);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_ctl.radix == RADIX_DEC) ? BK_CONVERT : BK_SIGN;
                end
            end
            BK_CONVERT:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = BK_SIGN;
                end
            end
            BK_SIGN:
            begin
                if (!ctl_reg.neg || room)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (step && (pos_reg == POS_W'(1)))
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = CH_SPACE;
        emit_last = 1'b0;
        step      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
            end
            BK_SIGN:
            begin
                emit      = ctl_reg.neg;
                emit_char = CH_MINUS;
            end
            BK_EMIT:
            begin
                if (show_digit)
                begin
                    emit      = 1'b1;
                    emit_char = digit_char(cur_digit, ctl_reg.upper);
                    emit_last = (pos_reg == POS_W'(1));
                end
                else if (show_fill)
                begin
                    emit      = 1'b1;
                    emit_char = ctl_reg.zero_fill ? CH_ZERO : CH_SPACE;
                end
                step = !emit || room;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NPOS; i++)
        begin
            adj[i] = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
        end

        ctl_next  = ctl_reg;
        mag_next  = mag_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        seen_next = seen_reg;
        for (int i = 0; i < NPOS; i++)
        begin
            digit_next[i] = digit_reg[i];
        end

        if (q_pop)
        begin
            ctl_next  = q_ctl;
            mag_next  = q_mag;
            cnt_next  = CNT_W'(VALUE_BITS);
            seen_next = 1'b0;
            case (q_ctl.radix)
                RADIX_HEX: pos_next = POS_W'(NHEX);
                RADIX_OCT: pos_next = POS_W'(NOCT);
                default:   pos_next = POS_W'(NDEC);
            endcase
            for (int i = 0; i < NPOS; i++)
            begin
                case (q_ctl.radix)
                    RADIX_HEX: digit_next[i] = pad[4*i +: 4];
                    RADIX_OCT: digit_next[i] = {1'b0, pad[3*i +: 3]};
                    default:   digit_next[i] = 4'd0;
                endcase
            end
        end
        else if (state_reg == BK_CONVERT)
        begin
            mag_next      = mag_reg << 1;
            cnt_next      = cnt_reg - CNT_W'(1);
            digit_next[0] = {adj[0][2:0], mag_reg[VALUE_BITS-1]};
            for (int i = 1; i < NPOS; i++)
            begin
                digit_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
        end
        else if ((state_reg == BK_EMIT) && step)
        begin
            pos_next  = pos_m1;
            seen_next = seen_reg || show_digit;
        end

        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (emit && room)
        begin
            out_valid_next = 1'b1;
            char_next      = emit_char;
            last_next      = emit_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg  <= ctl_next;
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
        for (int i = 0; i < NPOS; i++)
        begin
            digit_reg[i] <= digit_next[i];
        end
    end

endmodule

// ===== sv/integer_to_ascii_formatter_top.sv =====
// Each input beat is one number; it leaves as ASCII characters, most significant first, one
// per output beat, with last set on the final character. The character generator loads the
// number, converts it for decimal (one shift-add-3 step per value bit), emits the sign if
// negative and then walks each digit position of its radix, waiting while the output
// stalls. An input register and a short queue let the next numbers be accepted meanwhile.
module integer_to_ascii_formatter_top #(
    parameter int VALUE_BITS  = i2a_pkg::I2A_VALUE_BITS,
    parameter int QUEUE_DEPTH = i2a_pkg::I2A_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [VALUE_BITS-1:0]          value,
    input  logic [1:0]                     radix_select,
    input  logic                           is_signed,
    input  logic                           upper_case,
    input  logic [i2a_pkg::WIDTH_BITS-1:0] min_width,
    input  logic                           zero_fill,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     character,
    output logic                           last
);
    import i2a_pkg::*;

    localparam int QW = $bits(ctl_t) + VALUE_BITS;

    logic                  q_full;
    logic                  q_push;
    ctl_t                  f_ctl;
    logic [VALUE_BITS-1:0] f_mag;
    logic                  q_pop;
    logic                  q_not_empty;
    logic [QW-1:0]         q_data;
    ctl_t                  b_ctl;
    logic [VALUE_BITS-1:0] b_mag;

    assign b_ctl = q_data[QW-1:VALUE_BITS];
    assign b_mag = q_data[VALUE_BITS-1:0];

    i2a_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .radix_select (radix_select),
        .is_signed    (is_signed),
        .upper_case   (upper_case),
        .min_width    (min_width),
        .zero_fill    (zero_fill),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_ctl        (f_ctl),
        .q_mag        (f_mag)
    );

    i2a_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_ctl, f_mag}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    i2a_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_pop     (q_pop),
        .q_ctl     (b_ctl),
        .q_mag     (b_mag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

// ===== tb/tb_integer_to_ascii_formatter_top.sv =====
// Self-checking testbench for integer_to_ascii_formatter_top: directed numbers, then random ones.
// Every character is checked against the directed text or an in-bench formatter; depends on i2a_pkg and the top.
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter_top;

    import i2a_pkg::*;

    localparam logic [1:0] RADIX_UNUSED      = 2'd3;
    localparam int         RANDOM_PER_PHASE  = 45;
    localparam int         WATCHDOG_LIMIT    = 3000;
    localparam int         DRAIN_CYCLES      = 60;

    typedef struct packed {
        logic [31:0]           value;
        logic [1:0]            radix;
        logic                  sgn;
        logic                  upper;
        logic [WIDTH_BITS-1:0] width;
        logic                  zf;
    } number_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } char_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [31:0]           value = '0;
    logic [1:0]            radix_select = RADIX_DEC;
    logic                  is_signed = 1'b0;
    logic                  upper_case = 1'b0;
    logic [WIDTH_BITS-1:0] min_width = '0;
    logic                  zero_fill = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            character;
    logic                  last;

    string      beat_text = "";
    char_beat_t pending_chars[$];
    number_t    directed_numbers[$];
    string      directed_text[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         failures = 0;
    int         numbers_sent = 0;
    int         chars_checked = 0;
    int         idle_cycles = 0;
    bit         progress;
    char_beat_t expected_char;

    integer_to_ascii_formatter_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .radix_select (radix_select),
        .is_signed    (is_signed),
        .upper_case   (upper_case),
        .min_width    (min_width),
        .zero_fill    (zero_fill),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .character    (character),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Formats one number and queues its characters, most significant first.
    function automatic void predict_characters(input number_t num);
        char_beat_t  chars[$];
        logic [31:0] mag;
        logic [31:0] rest;
        int          base;
        int          positions;
        int          wid;
        int          d;
        logic [3:0]  digs[12];
        logic        seen;
        logic [7:0]  fill_ch;
        mag = num.value;
        wid = num.width;
        seen = 1'b0;
        fill_ch = num.zf ? CH_ZERO : CH_SPACE;
        if (num.radix == RADIX_HEX)
        begin
            base = 16;
        end
        else if (num.radix == RADIX_OCT)
        begin
            base = 8;
        end
        else
        begin
            base = 10;
        end
        if (base == 10 && num.sgn && mag[31])
        begin
            chars.push_back('{CH_MINUS, 1'b0});
            mag = 32'd0 - mag;
            wid = (wid > 0) ? wid - 1 : 0;
        end
        positions = 0;
        rest = '1;
        do
        begin
            rest = rest / base;
            positions++;
        end
        while (rest != 0);
        rest = mag;
        for (int p = 0; p < positions; p++)
        begin
            digs[p] = 4'(rest % base);
            rest = rest / base;
        end
        for (int p = positions; p >= 1; p--)
        begin
            d = digs[p - 1];
            if (d != 0 || seen || p == 1)
            begin
                if (d <= 9)
                begin
                    chars.push_back('{CH_ZERO + 8'(d), 1'b0});
                end
                else
                begin
                    chars.push_back('{(num.upper ? CH_UPPER : CH_LOWER) + 8'(d - 10), 1'b0});
                end
                seen = 1'b1;
            end
            else if (wid >= p)
            begin
                chars.push_back('{fill_ch, 1'b0});
            end
        end
        chars[chars.size() - 1].last = 1'b1;
        foreach (chars[i])
        begin
            pending_chars.push_back(chars[i]);
        end
    endfunction

    task automatic add_case(input number_t num, input string text);
        directed_numbers.push_back(num);
        directed_text.push_back(text);
    endtask

    task automatic send_number(input number_t num, input string text);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        value        <= num.value;
        radix_select <= num.radix;
        is_signed    <= num.sgn;
        upper_case   <= num.upper;
        min_width    <= num.width;
        zero_fill    <= num.zf;
        beat_text    <= text;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        numbers_sent++;
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (in_valid && !in_stall)
            begin
                progress = 1'b1;
                if (beat_text.len() > 0)
                begin
                    for (int i = 0; i < beat_text.len(); i++)
                    begin
                        pending_chars.push_back('{beat_text[i], i == beat_text.len() - 1});
                    end
                end
                else
                begin
                    predict_characters('{value, radix_select, is_signed, upper_case,
                                         min_width, zero_fill});
                end
            end
            if (out_valid && !out_stall)
            begin
                progress = 1'b1;
                if (pending_chars.size() == 0)
                begin
                    $error("character: nothing pending, got 8'h%02h", character);
                    failures++;
                end
                else
                begin
                    expected_char = pending_chars.pop_front();
                    chars_checked++;
                    if (character !== expected_char.character)
                    begin
                        $error("character: expected 8'h%02h, got 8'h%02h",
                               expected_char.character, character);
                        failures++;
                    end
                    if (last !== expected_char.last)
                    begin
                        $error("last: expected %0b, got %0b", expected_char.last, last);
                        failures++;
                    end
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_integer_to_ascii_formatter_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        number_t num;
        int      r;
        add_case('{32'd0, RADIX_DEC, 1'b0, 1'b0, 5'd0, 1'b0}, "0");
        add_case('{32'hFFFFFFFF, RADIX_DEC, 1'b0, 1'b0, 5'd0, 1'b0}, "4294967295");
        add_case('{32'hFFFFFFFF, RADIX_DEC, 1'b1, 1'b0, 5'd0, 1'b0}, "-1");
        add_case('{32'h80000000, RADIX_DEC, 1'b1, 1'b0, 5'd0, 1'b0}, "-2147483648");
        add_case('{32'h7FFFFFFF, RADIX_DEC, 1'b1, 1'b0, 5'd0, 1'b0}, "2147483647");
        add_case('{32'hFFFFFFFF, RADIX_HEX, 1'b0, 1'b1, 5'd0, 1'b0}, "FFFFFFFF");
        add_case('{32'hFFFFFFFF, RADIX_HEX, 1'b0, 1'b0, 5'd0, 1'b0}, "ffffffff");
        add_case('{32'hFFFFFFFF, RADIX_OCT, 1'b0, 1'b0, 5'd0, 1'b0}, "37777777777");
        add_case('{32'd0, RADIX_OCT, 1'b0, 1'b0, 5'd31, 1'b1}, "00000000000");
        add_case('{32'd0, RADIX_HEX, 1'b0, 1'b0, 5'd31, 1'b0}, "       0");
        add_case('{32'hFFFFFFFB, RADIX_DEC, 1'b1, 1'b0, 5'd0, 1'b1}, "-5");
        add_case('{32'hFFFFFFFB, RADIX_DEC, 1'b1, 1'b0, 5'd1, 1'b1}, "-5");
        add_case('{32'hFFFFFFFB, RADIX_DEC, 1'b1, 1'b0, 5'd3, 1'b1}, "-05");
        add_case('{32'd1234, RADIX_UNUSED, 1'b0, 1'b0, 5'd0, 1'b0}, "1234");
        add_case('{32'hFFFFFFD6, RADIX_UNUSED, 1'b1, 1'b0, 5'd0, 1'b0}, "-42");
        add_case('{32'hFFFFFFFF, RADIX_HEX, 1'b1, 1'b0, 5'd0, 1'b0}, "ffffffff");
        add_case('{32'h80000000, RADIX_OCT, 1'b1, 1'b0, 5'd0, 1'b0}, "20000000000");
        add_case('{32'd1234, RADIX_DEC, 1'b0, 1'b0, 5'd8, 1'b0}, "    1234");
        add_case('{32'd7, RADIX_DEC, 1'b0, 1'b0, 5'd31, 1'b1}, "0000000007");
        add_case('{32'h00ABCDEF, RADIX_HEX, 1'b0, 1'b1, 5'd8, 1'b1}, "00ABCDEF");
        add_case('{32'd0, RADIX_DEC, 1'b1, 1'b0, 5'd5, 1'b1}, "00000");
        add_case('{32'd8, RADIX_OCT, 1'b0, 1'b0, 5'd4, 1'b0}, "  10");
        add_case('{32'hDEADBEEF, RADIX_HEX, 1'b0, 1'b0, 5'd0, 1'b0}, "deadbeef");
        add_case('{32'hFFFFFFF9, RADIX_DEC, 1'b1, 1'b0, 5'd31, 1'b0}, "");
        add_case('{32'h80000000, RADIX_DEC, 1'b0, 1'b1, 5'd12, 1'b1}, "");
        add_case('{32'd0, RADIX_UNUSED, 1'b1, 1'b1, 5'd2, 1'b0}, "");

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 28 : (phase == 1) ? 50 : 0;
            recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 28 : 0;
            if (phase == 0)
            begin
                foreach (directed_numbers[i])
                begin
                    send_number(directed_numbers[i], directed_text[i]);
                end
            end
            repeat (RANDOM_PER_PHASE)
            begin
                case ($urandom_range(0, 5))
                    0: num.value = $urandom_range(0, 20);
                    1: num.value = 32'd0 - 32'($urandom_range(1, 100000));
                    2: num.value = 32'd1 << $urandom_range(0, 31);
                    3: num.value = 32'hFFFFFFFF - 32'($urandom_range(0, 20));
                    4: num.value = $urandom & (32'hFFFFFFFF >> $urandom_range(0, 31));
                    default: num.value = $urandom;
                endcase
                r = $urandom_range(0, 9);
                num.radix = (r == 9) ? RADIX_UNUSED : 2'(r % 3);
                num.sgn   = 1'($urandom_range(0, 1));
                num.upper = 1'($urandom_range(0, 1));
                num.width = ($urandom_range(0, 1) != 0) ? WIDTH_BITS'($urandom_range(0, 11))
                                                        : WIDTH_BITS'($urandom_range(0, 31));
                num.zf    = 1'($urandom_range(0, 1));
                send_number(num, "");
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Formatted %0d numbers (%0d directed) into %0d checked characters,",
                 numbers_sent, directed_numbers.size(), chars_checked);
        $display("in all radixes and fills under three sender and receiver idle patterns.");
        if (failures == 0)
        begin
            $display("tb_integer_to_ascii_formatter_top: PASS");
        end
        else
        begin
            $display("tb_integer_to_ascii_formatter_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/i2a_pkg.sv
sv/i2a_front.sv
sv/i2a_queue.sv
sv/i2a_back.sv
sv/integer_to_ascii_formatter_top.sv
tb/tb_integer_to_ascii_formatter_top.sv
